// File: design/fdsdc_pkg.sv
// Package for the scanned display counter: shared types, register
// indexes, count limits and the seven-segment decode.
// No dependencies.
package fdsdc_pkg;

  // Count width and limits
  localparam int unsigned CountW       = 14;
  localparam int unsigned NumBcdDigits = 4;
  localparam logic [CountW-1:0] CountMax = 14'd9999;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgDwellTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHoldPasses = 2'd1;

  // Register reset values
  localparam logic [CfgDataW-1:0] DwellTicksRst = 8'd1;
  localparam logic [CfgDataW-1:0] HoldPassesRst = 8'd21;

  typedef logic [3:0] bcd_digit_t;
  typedef logic [NumBcdDigits-1:0][3:0] bcd_word_t;

  // Step command for the counter
  typedef struct packed {
    logic inc;
    logic dec;
  } step_cmd_t;

  // Segment decode, bit7 = a ... bit1 = g, bit0 = dp
  function automatic logic [7:0] seg_decode(input bcd_digit_t digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'hfc;
      4'd1:    seg = 8'h60;
      4'd2:    seg = 8'hda;
      4'd3:    seg = 8'hf2;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'hb6;
      4'd6:    seg = 8'hbe;
      4'd7:    seg = 8'he0;
      4'd8:    seg = 8'hfe;
      4'd9:    seg = 8'hf6;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// File: design/four_digit_scanned_display_counter.sv
// Top level of the scanned display counter: tick input, scan and hold
// control, two-entry output buffer and configuration registers.
// Depends on fdsdc_pkg and fdsdc_bcd_counter.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | input     | in_valid_i / in_stall_o | up_button_level_i, down_button_level_i
//  out     | output    | out_valid_o / out_stall_i | segment_pattern_o, digit_enable_n_o,
//          |           |                        | count_value_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One tick is accepted per cycle while in_stall_o is low; its result is
// registered in the output buffer. The scan and count state update in the
// accepting cycle. A stalled result is held in the output register while a
// second one fills the skid register; the input stalls only when both are full.
// Reset clears count, scan position, hold state and the output buffer.
module four_digit_scanned_display_counter import fdsdc_pkg::*; #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                up_button_level_i,
  input  logic                down_button_level_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          segment_pattern_o,
  output logic [3:0]          digit_enable_n_o,
  output logic [CountW-1:0]   count_value_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned PosW = $clog2(NUM_DIGITS);
  localparam logic [PosW-1:0] PosLast = PosW'(NUM_DIGITS - 1);

  // Configuration registers
  logic [CfgDataW-1:0] dwell_ticks_q, hold_passes_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ticks_q <= DwellTicksRst;
      hold_passes_q <= HoldPassesRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgDwellTicks: dwell_ticks_q <= cfg_data_i;
        CfgHoldPasses: hold_passes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Scan and hold state
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      dwell_cnt_q, dwell_cnt_d;
  logic            holding_q, holding_d;
  logic [7:0]      hold_cnt_q, hold_cnt_d;
  logic            accept;

  // Output buffer
  logic                out_valid_q, skid_valid_q;
  logic [7:0]          seg_q, skid_seg_q;
  logic [3:0]          en_n_q, skid_en_n_q;
  logic [CountW-1:0]   cnt_q, skid_cnt_q;
  logic                out_fire;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;

  // Counter
  step_cmd_t         cmd;
  bcd_word_t         digits;
  logic [CountW-1:0] count_next;

  fdsdc_bcd_counter u_counter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .digits_o    (digits),
    .count_next_o(count_next)
  );

  // Advance dwell, position and hold; issue a step at the end of a pass
  always_comb begin
    logic       up, down;
    logic [7:0] dwell, dwell_inc, hold_inc;
    logic       apply;
    up          = !up_button_level_i;
    down        = !down_button_level_i;
    dwell       = (dwell_ticks_q == '0) ? 8'd1 : dwell_ticks_q;
    dwell_inc   = dwell_cnt_q + 8'd1;
    hold_inc    = hold_cnt_q + 8'd1;
    apply       = 1'b0;
    pos_d       = pos_q;
    dwell_cnt_d = dwell_cnt_q;
    holding_d   = holding_q;
    hold_cnt_d  = hold_cnt_q;
    if (accept) begin
      dwell_cnt_d = dwell_inc;
      if (dwell_inc >= dwell) begin
        dwell_cnt_d = '0;
        if (pos_q >= PosLast) begin
          pos_d = '0;
          if (holding_q) begin
            hold_cnt_d = hold_inc;
            if (hold_inc >= hold_passes_q) begin
              apply      = 1'b1;
              holding_d  = 1'b0;
              hold_cnt_d = '0;
            end
          end else if (up || down) begin
            if (hold_passes_q == '0) begin
              apply = 1'b1;
            end else begin
              holding_d  = 1'b1;
              hold_cnt_d = '0;
            end
          end
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
    cmd.inc = apply && up && !down;
    cmd.dec = apply && down && !up;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      dwell_cnt_q <= '0;
      holding_q   <= 1'b0;
      hold_cnt_q  <= '0;
    end else begin
      pos_q       <= pos_d;
      dwell_cnt_q <= dwell_cnt_d;
      holding_q   <= holding_d;
      hold_cnt_q  <= hold_cnt_d;
    end
  end

  // Decode the lit digit from the count before this tick
  logic [2:0]  weight;
  bcd_digit_t  lit_digit;
  logic [7:0]  seg_new;
  logic [3:0]  en_n_new;

  always_comb begin
    weight    = 3'(NUM_DIGITS - 1) - 3'(pos_q);
    en_n_new  = 4'hf;
    lit_digit = 4'd0;
    if (weight < 3'd4) begin
      en_n_new[weight[1:0]] = 1'b0;
      lit_digit             = digits[weight[1:0]];
    end
    seg_new = seg_decode(lit_digit);
  end

  // Output buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        seg_q  <= skid_seg_q;
        en_n_q <= skid_en_n_q;
        cnt_q  <= skid_cnt_q;
      end
    end else if (accept) begin
      if (out_valid_q && !out_fire) begin
        skid_seg_q  <= seg_new;
        skid_en_n_q <= en_n_new;
        skid_cnt_q  <= count_next;
      end else begin
        seg_q  <= seg_new;
        en_n_q <= en_n_new;
        cnt_q  <= count_next;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign segment_pattern_o = seg_q;
  assign digit_enable_n_o  = en_n_q;
  assign count_value_o     = cnt_q;

  // Checks on buffer and scan state
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid entry without head entry");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !holding_q |-> (hold_cnt_q == '0)) else $error("hold count running while idle");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLast) else $error("scan position out of range");

  a_no_step_mid_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.inc || cmd.dec) |-> (accept && pos_d == '0))
    else $error("count stepped away from the end of a pass");

endmodule

// File: design/fdsdc_bcd_counter.sv
// Saturating up/down counter kept both in binary and as decimal digits.
// Depends on fdsdc_pkg.
module fdsdc_bcd_counter import fdsdc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  step_cmd_t         cmd_i,
  output bcd_word_t         digits_o,
  output logic [CountW-1:0] count_next_o
);

  logic [CountW-1:0] count_q, count_d;
  bcd_word_t         digits_q, digits_d;

  // Step the decimal digits with a ripple carry or borrow
  always_comb begin
    logic carry;
    count_d  = count_q;
    digits_d = digits_q;
    carry    = 1'b1;
    if (cmd_i.inc && !cmd_i.dec && count_q < CountMax) begin
      count_d = count_q + 14'd1;
      for (int i = 0; i < NumBcdDigits; i++) begin
        if (carry) begin
          if (digits_q[i] == 4'd9) begin
            digits_d[i] = 4'd0;
          end else begin
            digits_d[i] = digits_q[i] + 4'd1;
            carry       = 1'b0;
          end
        end
      end
    end else if (cmd_i.dec && !cmd_i.inc && count_q != '0) begin
      count_d = count_q - 14'd1;
      for (int i = 0; i < NumBcdDigits; i++) begin
        if (carry) begin
          if (digits_q[i] == 4'd0) begin
            digits_d[i] = 4'd9;
          end else begin
            digits_d[i] = digits_q[i] - 4'd1;
            carry       = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      digits_q <= '0;
    end else begin
      count_q  <= count_d;
      digits_q <= digits_d;
    end
  end

  assign digits_o     = digits_q;
  assign count_next_o = count_d;

  // Count stays in range and the two forms agree
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountMax) else $error("count above full scale");

  a_bcd_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 14'(digits_q[3] * 1000 + digits_q[2] * 100 + digits_q[1] * 10
                   + digits_q[0])) else $error("decimal digits out of step");

  a_step_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_i.inc && !cmd_i.dec) |=> $stable(count_q))
    else $error("count moved without a step command");

endmodule
